// ===== src/bwlp_pkg.sv =====
`default_nettype none
package bwlp_pkg;

	// field widths
	localparam int BYTES_W = 31;
	localparam int TIME_W  = 48;
	localparam int RATE_W  = 32;
	localparam int OUTC_W  = 3;

	// serial multiplier: 48 x 32
	localparam int MA_W = 48;
	localparam int MB_W = 32;
	localparam int MP_W = MA_W + MB_W;

	// serial divider: 68-bit dividend, 32-bit divisor, 48-bit quotient with overflow flag
	localparam int DVD_W = 68;
	localparam int DVS_W = 32;
	localparam int Q_W   = 48;

	localparam logic [TIME_W-1:0] MAX48        = {TIME_W{1'b1}};
	localparam logic [TIME_W-1:0] RESYNC_US    = 48'd10000000;
	localparam logic [TIME_W-1:0] MIN_INTVL_US = 48'd100;
	localparam logic [DVS_W-1:0]  USEC_PER_SEC = 32'd1000000;

	typedef enum logic [OUTC_W-1:0] {
		OUT_BYPASS   = 3'd0,
		OUT_RESYNC   = 3'd1,
		OUT_TOO_SOON = 3'd2,
		OUT_NO_PAUSE = 3'd3,
		OUT_PAUSE    = 3'd4
	} outcome_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL_D,
		ST_DIV_D,
		ST_DRAIN,
		ST_MUL_P,
		ST_DIV_P,
		ST_DONE
	} state_t;

	// divider status toward the controller
	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== src/bwlp_mul.sv =====
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module bwlp_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bwlp_pkg::MA_W-1:0]     a,
	input  wire logic [bwlp_pkg::MB_W-1:0]     b,
	output logic                               done,
	output logic [bwlp_pkg::MP_W-1:0]          prod
);

	localparam int CNT_W = $clog2(bwlp_pkg::MB_W);

	logic [bwlp_pkg::MA_W-1:0] a_q;
	logic [bwlp_pkg::MA_W-1:0] hi_q;
	logic [bwlp_pkg::MB_W-1:0] lo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [bwlp_pkg::MA_W:0]   sum;

	// conditional add of the multiplicand into the upper half
	assign sum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, a_q}) : {1'b0, hi_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bwlp_pkg::MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[bwlp_pkg::MA_W:1];
			lo_q <= {sum[0], lo_q[bwlp_pkg::MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule
`default_nettype wire

// ===== src/bwlp_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle, quotient overflow flagged via ovf.
module bwlp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bwlp_pkg::DVD_W-1:0]    dividend,
	input  wire logic [bwlp_pkg::DVS_W-1:0]    divisor,
	output bwlp_pkg::div_stat_t                stat,
	output logic [bwlp_pkg::Q_W-1:0]           quot
);

	localparam int CNT_W = $clog2(bwlp_pkg::DVD_W);

	logic [bwlp_pkg::DVD_W-1:0] dvd_q;
	logic [bwlp_pkg::DVS_W-1:0] dvs_q;
	logic [bwlp_pkg::DVS_W-1:0] rem_q;
	logic [bwlp_pkg::Q_W-1:0]   quot_q;
	logic                       ovf_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bwlp_pkg::DVS_W:0]   trial;
	logic [bwlp_pkg::DVS_W:0]   diff;
	logic                       ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, dvd_q[bwlp_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(bwlp_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath; a one shifted past the quotient top marks overflow
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[bwlp_pkg::DVD_W-2:0], 1'b0};
			rem_q  <= ge ? diff[bwlp_pkg::DVS_W-1:0] : trial[bwlp_pkg::DVS_W-1:0];
			quot_q <= {quot_q[bwlp_pkg::Q_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[bwlp_pkg::Q_W-1];
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quot      = quot_q;

endmodule
`default_nettype wire

// ===== src/bandwidth_limit_pacer.sv =====
`default_nettype none
// channel  dir  handshake          payload
// s_axis   in   s_tvalid/s_tready  s_tdata: byte_count, now_us
// m_axis   out  m_tvalid/m_tready  m_tdata: sleep_us; m_tuser: outcome
// cfg      in   cfg_we             cfg_wdata: rate_limit
//
// One word at a time. Bypass, resync and too-soon words go from accept through
// check and done to the output register. A paced word takes two passes of the
// serial multiplier and two of the serial divider.
// Reset clears the pending count, window start and rate limit.
// The result sits in an output register; a stalled m_tready holds it and
// the next word is only taken once its result can be loaded.
module bandwidth_limit_pacer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,   // [30:0] byte_count, [78:31] now_us, [79] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [47:0] sleep_us
	output logic [7:0]       m_tuser,   // [2:0] outcome, [7:3] zero
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata  // rate_limit
);

	localparam int TW = bwlp_pkg::TIME_W;

	bwlp_pkg::state_t   state_q, state_nx;
	logic [bwlp_pkg::RATE_W-1:0]  rate_q;
	logic [TW-1:0]                pending_q;
	logic [TW-1:0]                wstart_q;
	logic [bwlp_pkg::BYTES_W-1:0] bytes_q;
	logic [TW-1:0]                now_q;
	logic [TW-1:0]                sleep_q;
	bwlp_pkg::outcome_t           outc_q;
	logic                         m_valid_q;
	logic [TW-1:0]                m_sleep_q;
	bwlp_pkg::outcome_t           m_outc_q;

	logic        s_acc;
	logic        out_load;
	logic        bypass, backwards, resync, too_soon;
	logic [TW-1:0] elapsed;
	logic [TW:0]   acc_sum;
	logic [TW-1:0] pend_acc;

	logic                         mul_start;
	logic [bwlp_pkg::MA_W-1:0]    mul_a;
	logic [bwlp_pkg::MB_W-1:0]    mul_b;
	logic                         mul_done;
	logic [bwlp_pkg::MP_W-1:0]    mul_prod;
	logic                         div_start;
	logic [bwlp_pkg::DVS_W-1:0]   div_dvs;
	bwlp_pkg::div_stat_t          div_stat;
	logic [bwlp_pkg::Q_W-1:0]     div_quot;

	logic [TW-1:0] pause;
	logic          do_pause;
	logic [TW:0]   ws_sum;
	logic [TW-1:0] ws_sat;

	// units
	bwlp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	bwlp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod[bwlp_pkg::DVD_W-1:0]),
		.divisor  (div_dvs),
		.stat     (div_stat),
		.quot     (div_quot)
	);

	// window checks on the captured word
	assign bypass    = (bytes_q == '0) || (rate_q == '0);
	assign backwards = (now_q < wstart_q);
	assign elapsed   = now_q - wstart_q;
	assign resync    = backwards || (elapsed > bwlp_pkg::RESYNC_US);
	assign too_soon  = (elapsed < bwlp_pkg::MIN_INTVL_US);
	assign acc_sum   = {1'b0, pending_q} + (TW+1)'(bytes_q);
	assign pend_acc  = acc_sum[TW] ? bwlp_pkg::MAX48 : acc_sum[TW-1:0];

	// pause decision
	assign pause    = div_stat.ovf ? bwlp_pkg::MAX48 : div_quot;
	assign do_pause = (pause > bwlp_pkg::MIN_INTVL_US);
	assign ws_sum   = {1'b0, now_q} + {1'b0, pause};
	assign ws_sat   = ws_sum[TW] ? bwlp_pkg::MAX48 : ws_sum[TW-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bwlp_pkg::ST_IDLE:  if (s_acc) state_nx = bwlp_pkg::ST_CHECK;
			bwlp_pkg::ST_CHECK: begin
				if (bypass || resync || too_soon) state_nx = bwlp_pkg::ST_DONE;
				else state_nx = bwlp_pkg::ST_MUL_D;
			end
			bwlp_pkg::ST_MUL_D: if (mul_done) state_nx = bwlp_pkg::ST_DIV_D;
			bwlp_pkg::ST_DIV_D: if (div_stat.done) state_nx = bwlp_pkg::ST_DRAIN;
			bwlp_pkg::ST_DRAIN: state_nx = bwlp_pkg::ST_MUL_P;
			bwlp_pkg::ST_MUL_P: if (mul_done) state_nx = bwlp_pkg::ST_DIV_P;
			bwlp_pkg::ST_DIV_P: if (div_stat.done) state_nx = bwlp_pkg::ST_DONE;
			bwlp_pkg::ST_DONE:  if (out_load) state_nx = bwlp_pkg::ST_IDLE;
			default:            state_nx = bwlp_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		mul_start = 1'b0;
		mul_a     = TW'(elapsed);
		mul_b     = rate_q;
		div_start = 1'b0;
		div_dvs   = rate_q;
		unique case (state_q)
			bwlp_pkg::ST_CHECK: mul_start = !(bypass || resync || too_soon);
			bwlp_pkg::ST_MUL_D: begin
				div_start = mul_done;
				div_dvs   = bwlp_pkg::USEC_PER_SEC;
			end
			bwlp_pkg::ST_DRAIN: begin
				mul_start = 1'b1;
				mul_a     = pending_q;
				mul_b     = bwlp_pkg::USEC_PER_SEC;
			end
			bwlp_pkg::ST_MUL_P: div_start = mul_done;
			default: ;
		endcase
	end

	assign s_acc    = s_tvalid && (state_q == bwlp_pkg::ST_IDLE);
	assign out_load = (state_q == bwlp_pkg::ST_DONE) && (!m_valid_q || m_tready);

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bwlp_pkg::ST_IDLE;
			rate_q    <= '0;
			pending_q <= '0;
			wstart_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) rate_q <= cfg_wdata;

			if (state_q == bwlp_pkg::ST_CHECK && !bypass) begin
				if (resync) begin
					pending_q <= TW'(bytes_q);
					wstart_q  <= now_q;
				end else begin
					pending_q <= pend_acc;
				end
			end

			// drain, clamped at zero
			if (state_q == bwlp_pkg::ST_DIV_D && div_stat.done) begin
				pending_q <= (pending_q > div_quot) ? (pending_q - div_quot) : '0;
			end

			if (state_q == bwlp_pkg::ST_DIV_P && div_stat.done) begin
				if (do_pause) begin
					pending_q <= '0;
					wstart_q  <= ws_sat;
				end else begin
					wstart_q <= now_q;
				end
			end

			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			bytes_q <= s_tdata[30:0];
			now_q   <= s_tdata[78:31];
		end
		if (state_q == bwlp_pkg::ST_CHECK) begin
			sleep_q <= '0;
			priority if (bypass)   outc_q <= bwlp_pkg::OUT_BYPASS;
			else if (resync)       outc_q <= bwlp_pkg::OUT_RESYNC;
			else if (too_soon)     outc_q <= bwlp_pkg::OUT_TOO_SOON;
			else                   outc_q <= bwlp_pkg::OUT_NO_PAUSE;
		end
		if (state_q == bwlp_pkg::ST_DIV_P && div_stat.done) begin
			sleep_q <= do_pause ? pause : '0;
			outc_q  <= do_pause ? bwlp_pkg::OUT_PAUSE : bwlp_pkg::OUT_NO_PAUSE;
		end
		if (out_load) begin
			m_sleep_q <= sleep_q;
			m_outc_q  <= outc_q;
		end
	end

	assign s_tready = (state_q == bwlp_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sleep_q;
	assign m_tuser  = {5'b0, m_outc_q};

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam int WDOG_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [30:0] BYTES_MAX = {bwlp_pkg::BYTES_W{1'b1}};

	typedef struct packed {
		logic [bwlp_pkg::BYTES_W-1:0] nbytes;
		logic [bwlp_pkg::TIME_W-1:0]  stamp;
	} xfer_word_t;

	typedef struct packed {
		logic [bwlp_pkg::TIME_W-1:0] sleep;
		bwlp_pkg::outcome_t          outcome;
	} pace_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // [30:0] byte_count, [78:31] now_us, [79] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [47:0] sleep_us
	logic [7:0]  m_tuser;        // [2:0] outcome, [7:3] zero
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	bandwidth_limit_pacer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// pacer state as the testbench sees it
	logic [bwlp_pkg::RATE_W-1:0] lim_rate = '0;
	logic [bwlp_pkg::TIME_W-1:0] pend_cnt = '0;
	logic [bwlp_pkg::TIME_W-1:0] win_t0 = '0;

	xfer_word_t word_q[$];
	pace_res_t  pace_q[$];
	xfer_word_t cur_word;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int err_cnt = 0;
	int words_in = 0;
	int words_out = 0;
	int rate_writes = 0;
	int idle_cycles = 0;
	int outc_seen[5] = '{default: 0};
	logic [bwlp_pkg::TIME_W-1:0] gen_now;

	// expected pause decision for one transfer report; updates the state
	function automatic pace_res_t pace_predict(logic [bwlp_pkg::BYTES_W-1:0] nb,
			logic [bwlp_pkg::TIME_W-1:0] now);
		pace_res_t r;
		logic [bwlp_pkg::TIME_W:0]   acc;
		logic [bwlp_pkg::TIME_W:0]   ws;
		logic [bwlp_pkg::TIME_W-1:0] el;
		logic [63:0]                 drain;
		logic [79:0]                 q;
		r.sleep = '0;
		r.outcome = bwlp_pkg::OUT_BYPASS;
		if (nb != 0 && lim_rate != 0) begin
			el = now - win_t0;
			acc = {1'b0, pend_cnt} + (bwlp_pkg::TIME_W+1)'(nb);
			pend_cnt = acc[bwlp_pkg::TIME_W] ? bwlp_pkg::MAX48 : acc[bwlp_pkg::TIME_W-1:0];
			if (now < win_t0 || el > bwlp_pkg::RESYNC_US) begin
				pend_cnt = bwlp_pkg::TIME_W'(nb);
				win_t0 = now;
				r.outcome = bwlp_pkg::OUT_RESYNC;
			end else if (el < bwlp_pkg::MIN_INTVL_US) begin
				r.outcome = bwlp_pkg::OUT_TOO_SOON;
			end else begin
				drain = (64'(el) * 64'(lim_rate)) / 64'(bwlp_pkg::USEC_PER_SEC);
				pend_cnt = (64'(pend_cnt) > drain) ?
					pend_cnt - drain[bwlp_pkg::TIME_W-1:0] : '0;
				q = (80'(pend_cnt) * 80'(bwlp_pkg::USEC_PER_SEC)) / 80'(lim_rate);
				if (q > 80'(bwlp_pkg::MAX48))
					q = 80'(bwlp_pkg::MAX48);
				if (q > 80'(bwlp_pkg::MIN_INTVL_US)) begin
					r.sleep = q[bwlp_pkg::TIME_W-1:0];
					pend_cnt = '0;
					ws = {1'b0, now} + {1'b0, q[bwlp_pkg::TIME_W-1:0]};
					win_t0 = ws[bwlp_pkg::TIME_W] ? bwlp_pkg::MAX48 : ws[bwlp_pkg::TIME_W-1:0];
					r.outcome = bwlp_pkg::OUT_PAUSE;
				end else begin
					win_t0 = now;
					r.outcome = bwlp_pkg::OUT_NO_PAUSE;
				end
			end
		end
		return r;
	endfunction

	// input driver: predict on accept, then offer the next word or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pace_q.push_back(pace_predict(cur_word.nbytes, cur_word.stamp));
				words_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_word = word_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {1'b0, cur_word.stamp, cur_word.nbytes};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compare each result word, then pick next tready
	always @(posedge clk) begin
		pace_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (m_tuser[2:0] < 3'd5)
				outc_seen[m_tuser[2:0]]++;
			if (pace_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word: sleep_us %0d outcome %0d",
					$time, m_tdata, m_tuser[2:0]);
			end else begin
				e = pace_q.pop_front();
				if (m_tdata !== e.sleep) begin
					err_cnt++;
					$display("%0t: sleep_us expected %0d actual %0d", $time, e.sleep, m_tdata);
				end
				if (m_tuser[2:0] !== e.outcome) begin
					err_cnt++;
					$display("%0t: outcome expected %0d actual %0d",
						$time, e.outcome, m_tuser[2:0]);
				end
			end
		end
		// long hold-off when requested, else random stalls
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
			$display("bandwidth_limit_pacer: mismatch");
			$finish;
		end
	end

	task automatic push_word(logic [bwlp_pkg::BYTES_W-1:0] nb,
			logic [bwlp_pkg::TIME_W-1:0] now);
		xfer_word_t w;
		w.nbytes = nb;
		w.stamp = now;
		word_q.push_back(w);
	endtask

	// all words sent and answered, then idle before returning
	task automatic wait_idle();
		do
			@(negedge clk);
		while (word_q.size() != 0 || s_tvalid || pace_q.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_rate(logic [bwlp_pkg::RATE_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		lim_rate = v;
		rate_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// plausible caller traffic: time mostly moves forward, bytes near the allowance
	task automatic queue_paced_words(int n);
		int sel;
		logic [bwlp_pkg::TIME_W-1:0] step;
		logic [63:0] allow;
		logic [63:0] nb64;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			step = 48'd1000;
			if (sel < 8) begin
				if (gen_now > 48'd1000)
					gen_now = gen_now - 48'($urandom_range(1, 1000));
			end else begin
				if (sel < 20)
					step = 48'($urandom_range(0, 99));
				else if (sel < 85)
					step = 48'($urandom_range(100, 5000));
				else if (sel < 95)
					step = 48'($urandom_range(5000, 10000000));
				else
					step = 48'($urandom_range(9999000, 12000000));
				gen_now = gen_now + step;
				if (gen_now > bwlp_pkg::MAX48 - 48'd20000000)
					gen_now = {16'd0, $urandom};
			end
			allow = (64'(step) * 64'(lim_rate)) / 64'(bwlp_pkg::USEC_PER_SEC);
			nb64 = allow * 64'($urandom_range(0, 250)) / 64'd100 + 64'($urandom_range(0, 3));
			if (nb64 > 64'(BYTES_MAX))
				nb64 = 64'(BYTES_MAX);
			if (nb64 == 0)
				nb64 = 64'd1;
			sel = $urandom_range(99);
			if (sel < 5)
				push_word('0, gen_now);
			else if (sel < 8)
				push_word(bwlp_pkg::BYTES_W'($urandom), gen_now);
			else if (sel < 10)
				push_word(nb64[bwlp_pkg::BYTES_W-1:0],
					{16'($urandom_range(0, 65535)), $urandom});
			else
				push_word(nb64[bwlp_pkg::BYTES_W-1:0], gen_now);
		end
	endtask

	// stimulus sequencer
	initial begin
		logic [bwlp_pkg::RATE_W-1:0] phase_rate[8];
		int idle_send[4];
		int idle_stall[4];
		phase_rate = '{32'd1000000, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1000};
		idle_send = '{0, 60, 0, 16};
		idle_stall = '{0, 0, 60, 16};
		phase_rate[3] = $urandom;
		phase_rate[4] = $urandom_range(1, 100000);
		phase_rate[6] = $urandom_range(1000, 200000000);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// limiter off after reset: everything bypasses
		push_word(BYTES_MAX, '0);
		push_word('0, bwlp_pkg::MAX48);
		wait_idle();

		// slow link: too soon, exact 100 us boundary, backwards clock, 10 s edge
		set_rate(32'd1000);
		push_word(BYTES_MAX, 48'd0);
		push_word('0, 48'd5);
		push_word(31'd1, 48'd50);
		push_word(31'd1, 48'd100);
		push_word(31'd1, 48'd200);
		push_word(31'd1, 48'd10000200);
		push_word(31'd1, 48'd20000201);
		push_word(31'd1, bwlp_pkg::MAX48);
		push_word(31'd1, bwlp_pkg::MAX48);
		wait_idle();

		// one byte per second: pause and window start both saturate
		set_rate(32'd1);
		push_word(BYTES_MAX, bwlp_pkg::MAX48 - 48'd200);
		push_word(BYTES_MAX, bwlp_pkg::MAX48 - 48'd100);
		push_word(31'd1, bwlp_pkg::MAX48 - 48'd50);
		wait_idle();

		// 1 byte/us: pause just above and at the 100 us threshold, drain past zero
		set_rate(32'd1000000);
		push_word(31'd1, 48'd1000);
		push_word(31'd200, 48'd1100);
		push_word(31'd200, 48'd1301);
		push_word(31'd50, 48'd1401);
		push_word(31'd1, 48'd1501);
		wait_idle();

		// fastest rate
		set_rate(32'hFFFFFFFF);
		push_word(BYTES_MAX, 48'd2000);
		push_word(BYTES_MAX, 48'd3000);
		wait_idle();

		// random traffic, phases rotating through the idle patterns
		for (int p = 0; p < 8; p++) begin
			send_idle_pct = idle_send[p % 4];
			stall_pct = idle_stall[p % 4];
			set_rate(phase_rate[p]);
			gen_now = {8'd0, 8'($urandom_range(0, 255)), $urandom};
			queue_paced_words(phase_rate[p] == 0 ? 30 : 200);
			// receiver holds off while the sender keeps offering
			if (p == 0)
				hold_seq++;
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("run covered %0d words under %0d rate settings, incl. a %0d-cycle output hold",
			words_in, rate_writes, HOLD_CYCLES);
		$display("outcomes: bypass %0d, resync %0d, too soon %0d, no pause %0d, pause %0d",
			outc_seen[0], outc_seen[1], outc_seen[2], outc_seen[3], outc_seen[4]);
		if (err_cnt == 0 && pace_q.size() == 0 && words_out == words_in)
			$display("bandwidth_limit_pacer: match");
		else
			$display("bandwidth_limit_pacer: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
